/* rtl/alpr_pkg.sv */
// ----------------------------------------------------------------------------
// alpr_pkg
// Shared types and constants for the arc-length polyline resampler.
// ----------------------------------------------------------------------------
package alpr_pkg;

    localparam int unsigned MaxPointsDefault = 64;
    localparam int unsigned CoordWidth       = 24;
    localparam int unsigned LenWidth         = 32;
    localparam int unsigned CountWidth       = 7;
    localparam logic [CountWidth-1:0] TargetCountReset = 7'd30;
    localparam logic [CountWidth-1:0] TargetCountMax   = 7'd64;

    // request to the iterative divider
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;

endpackage

/* rtl/alpr_sqrt.sv */
// ----------------------------------------------------------------------------
// alpr_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module alpr_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [49:0] radicand,
    output logic        done,
    output logic [24:0] root
);
    logic [49:0] rem_reg, rem_next;
    logic [49:0] res_reg, res_next;
    logic [49:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        trial     = res_reg + bit_reg;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = 50'd1 << 48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 50'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = busy_reg && (bit_reg == 50'd1);
    assign root = (rem_reg >= trial) ? 25'((res_reg >> 1) + bit_reg)
                                     : 25'(res_reg >> 1);
endmodule

/* rtl/alpr_div.sv */
// ----------------------------------------------------------------------------
// alpr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alpr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  alpr_pkg::div_req_t req,
    output alpr_pkg::div_rsp_t rsp
);
    logic [47:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[32:0], quo_reg[47]};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            cnt_next  = 6'd47;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (req.start) den_reg <= req.den;
    end

    assign rsp.done = busy_reg && (cnt_reg == 6'd0);
    assign rsp.quo  = (shifted >= {1'b0, den_reg}) ? {quo_reg[46:0], 1'b1}
                                                   : {quo_reg[46:0], 1'b0};
endmodule

/* rtl/arc_length_polyline_resampler_core.sv */
// ----------------------------------------------------------------------------
// arc_length_polyline_resampler_core
// Polyline loader with running arc length and evenly spaced resampling.
// ----------------------------------------------------------------------------
// Points are loaded one word at a time into a point memory and a length
// memory, both synchronous RAMs with registered read data. Each point passes
// from acceptance to the next ready through the accept state, a read of the
// previous entry with the squared-distance step, the square-root start, a
// bit-serial square root and a decide state. On the word marked last_point
// the block emits either the stored points again (fewer than two points,
// target_count zero, or zero total length), or target_count resampled
// points, capped at 64. A resampled point takes a divide for its target
// length, a linear walk over the length memory (the walk never moves back),
// a fraction divide (cut short when the fraction is zero) and the states
// to multiply, add and output. A stalled output word holds the block.
// Dropped points set dropped_points on every result of that run. No
// clearing pass is needed after reset.
module arc_length_polyline_resampler_core #(
    parameter int unsigned MAX_POINTS = alpr_pkg::MaxPointsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [23:0] s_px,
    input  logic signed [23:0] s_py,
    input  logic        s_last_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [23:0] m_rx,
    output logic signed [23:0] m_ry,
    output logic        m_end_of_run,
    output logic        m_dropped_points
);
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000_0000_0000_0001,
        ST_LRD    = 16'b0000_0000_0000_0010,
        ST_LSQ    = 16'b0000_0000_0000_0100,
        ST_LSQRT  = 16'b0000_0000_0000_1000,
        ST_DECIDE = 16'b0000_0000_0001_0000,
        ST_PRD    = 16'b0000_0000_0010_0000,
        ST_POUT   = 16'b0000_0000_0100_0000,
        ST_TDIV   = 16'b0000_0000_1000_0000,
        ST_WRD    = 16'b0000_0001_0000_0000,
        ST_WCHK   = 16'b0000_0010_0000_0000,
        ST_FDIV   = 16'b0000_0100_0000_0000,
        ST_MUL    = 16'b0000_1000_0000_0000,
        ST_ADD    = 16'b0001_0000_0000_0000,
        ST_ROUT   = 16'b0010_0000_0000_0000,
        ST_TOT    = 16'b0100_0000_0000_0000,
        ST_PRDX   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [47:0] pmem [MAX_POINTS];
    logic [31:0] lmem [MAX_POINTS];
    logic        p_we, l_we;
    logic [AW-1:0] p_waddr, p_raddr, l_waddr, l_raddr;
    logic [47:0] p_wdata, p_rdata;
    logic [31:0] l_wdata, l_rdata;

    always_ff @(posedge aclk) begin
        if (p_we) pmem[p_waddr] <= p_wdata;
        p_rdata <= pmem[p_raddr];
    end
    always_ff @(posedge aclk) begin
        if (l_we) lmem[l_waddr] <= l_wdata;
        l_rdata <= lmem[l_raddr];
    end

    logic [6:0]    tc_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic          last_reg;
    logic signed [23:0] x_reg, y_reg;
    logic [49:0]   d2_reg;
    logic [31:0]   total_reg, t_reg, s0_reg, s1_reg;
    logic [6:0]    i_reg, tcs_reg;
    logic [CW-1:0] u_reg;
    logic signed [23:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [16:0]   frac_reg;
    logic signed [42:0] px_reg, py_reg;
    logic          phase_reg;
    logic signed [23:0] o_rx_reg, o_ry_reg;
    logic          o_eor_reg, o_drop_reg, o_valid_reg;

    logic sq_start, sq_done;
    logic [24:0] sq_root;
    alpr_pkg::div_req_t dreq;
    alpr_pkg::div_rsp_t drsp;

    alpr_sqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .radicand(d2_reg),
                      .done(sq_done), .root(sq_root));
    alpr_div  u_div  (.aclk, .aresetn, .req(dreq), .rsp(drsp));

    logic signed [24:0] dx, dy;
    logic signed [49:0] dx_sq, dy_sq;
    logic [6:0] tc_sat;
    logic pass;
    logic [CW-1:0] cnt_m1;
    logic [31:0] seg_d;
    logic signed [42:0] offx, offy;

    assign dx     = 25'(x_reg) - 25'(signed'(p_rdata[47:24]));
    assign dy     = 25'(y_reg) - 25'(signed'(p_rdata[23:0]));
    assign dx_sq  = dx * dx;
    assign dy_sq  = dy * dy;
    assign tc_sat = (tc_reg > alpr_pkg::TargetCountMax) ? alpr_pkg::TargetCountMax : tc_reg;
    assign cnt_m1 = cnt_reg - CW'(1);
    assign pass   = (cnt_reg < CW'(2)) || (tcs_reg == 7'd0) || (total_reg == 32'd0);
    // segment length, with the start length still on the read port
    assign seg_d  = s1_reg - l_rdata;
    // round half up: floor((p + 32768) / 65536), arithmetic shift is floor
    assign offx   = (px_reg + 43'sd32768) >>> 16;
    assign offy   = (py_reg + 43'sd32768) >>> 16;

    assign s_ready = (state_reg == ST_IDLE) && !o_valid_reg;

    always_comb begin
        state_next = state_reg;
        p_we = 1'b0; l_we = 1'b0;
        p_waddr = cnt_reg[AW-1:0]; l_waddr = cnt_reg[AW-1:0];
        p_wdata = {x_reg, y_reg};   l_wdata = l_rdata + 32'(sq_root);
        p_raddr = '0; l_raddr = '0;
        sq_start = 1'b0;
        dreq = '0;
        unique case (state_reg)
            ST_IDLE: begin
                p_raddr = cnt_m1[AW-1:0];
                l_raddr = cnt_m1[AW-1:0];
                if (s_valid && s_ready) begin
                    if (cnt_reg < CW'(MAX_POINTS)) begin
                        p_we = 1'b1; p_wdata = {s_px, s_py};
                        if (cnt_reg == '0) begin
                            l_we = 1'b1; l_wdata = '0;
                        end
                    end
                    state_next = ST_LRD;
                end
            end
            ST_LRD: begin
                p_raddr = cnt_m1[AW-1:0];
                l_raddr = cnt_m1[AW-1:0];
                state_next = ST_LSQ;
            end
            ST_LSQ: begin
                p_raddr = cnt_m1[AW-1:0];
                l_raddr = cnt_m1[AW-1:0];
                sq_start = 1'b1;
                state_next = ST_LSQRT;
            end
            ST_LSQRT: begin
                p_raddr = cnt_m1[AW-1:0];
                l_raddr = cnt_m1[AW-1:0];
                if (sq_done) begin
                    // extend the running length past the previous point
                    if (cnt_reg != '0 && cnt_reg < CW'(MAX_POINTS)) l_we = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                l_raddr = cnt_m1[AW-1:0];
                state_next = last_reg ? ST_TOT : ST_IDLE;
            end
            ST_TOT: begin
                state_next = ST_PRD;
            end
            ST_PRD: begin
                if (pass) begin
                    p_raddr = i_reg[AW-1:0];
                    state_next = (i_reg == 7'(cnt_reg)) ? ST_IDLE : ST_PRDX;
                end else if (i_reg == tcs_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    dreq.start = 1'b1;
                    dreq.num = 48'(total_reg) * 48'(i_reg);
                    dreq.den = (tcs_reg > 7'd1) ? 33'(tcs_reg - 7'd1) : 33'd1;
                    state_next = ST_TDIV;
                end
            end
            ST_PRDX: begin
                p_raddr = i_reg[AW-1:0];
                state_next = ST_POUT;
            end
            ST_POUT: begin
                p_raddr = i_reg[AW-1:0];
                if (!o_valid_reg) state_next = ST_PRD;
            end
            ST_TDIV: begin
                l_raddr = u_reg[AW-1:0];
                if (drsp.done) state_next = ST_WRD;
            end
            ST_WRD: begin
                l_raddr = u_reg[AW-1:0];
                p_raddr = u_reg[AW-1:0];
                state_next = ST_WCHK;
            end
            ST_WCHK: begin
                l_raddr = AW'(u_reg - CW'(1));
                p_raddr = AW'(u_reg - CW'(1));
                if ((u_reg < cnt_m1) && (l_rdata < t_reg)) begin
                    state_next = ST_WRD;
                end else begin
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV: begin
                if (!phase_reg) begin
                    dreq.start = 1'b1;
                    dreq.num = (48'(t_reg - l_rdata) << 17) + 48'(seg_d);
                    dreq.den = {seg_d, 1'b0};
                end else if (drsp.done || !(s1_reg > s0_reg && t_reg > s0_reg)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: state_next = ST_ADD;
            ST_ADD: state_next = ST_ROUT;
            ST_ROUT: begin
                if (!o_valid_reg) state_next = ST_PRD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tc_reg      <= alpr_pkg::TargetCountReset;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            o_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) tc_reg <= cfg_wdata;
            if (o_valid_reg && m_ready) o_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        x_reg <= s_px; y_reg <= s_py;
                        last_reg <= s_last_point;
                        if (cnt_reg >= CW'(MAX_POINTS)) ovf_reg <= 1'b1;
                    end
                end
                ST_LRD: begin
                    d2_reg <= unsigned'(dx_sq) + unsigned'(dy_sq);
                end
                ST_LSQRT: begin
                    if (sq_done && cnt_reg < CW'(MAX_POINTS)) begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_TOT: begin
                    total_reg <= (cnt_reg == '0) ? 32'd0 : l_rdata;
                    tcs_reg   <= tc_sat;
                    i_reg     <= '0;
                    u_reg     <= CW'(1);
                    o_drop_reg <= ovf_reg;
                end
                ST_PRD: begin
                    if (pass && i_reg == 7'(cnt_reg)) begin
                        cnt_reg <= '0; ovf_reg <= 1'b0;
                    end
                    if (!pass && i_reg == tcs_reg) begin
                        cnt_reg <= '0; ovf_reg <= 1'b0;
                    end
                end
                ST_POUT: begin
                    if (!o_valid_reg) begin
                        o_valid_reg <= 1'b1;
                        o_rx_reg <= signed'(p_rdata[47:24]);
                        o_ry_reg <= signed'(p_rdata[23:0]);
                        o_eor_reg <= (i_reg + 7'd1) == 7'(cnt_reg);
                        i_reg <= i_reg + 7'd1;
                    end
                end
                ST_TDIV: begin
                    if (drsp.done) t_reg <= (tcs_reg > 7'd1) ? drsp.quo[31:0] : 32'd0;
                end
                ST_WCHK: begin
                    s1_reg <= l_rdata;
                    x1_reg <= signed'(p_rdata[47:24]);
                    y1_reg <= signed'(p_rdata[23:0]);
                    if ((u_reg < cnt_m1) && (l_rdata < t_reg)) u_reg <= u_reg + CW'(1);
                    phase_reg <= 1'b0;
                end
                ST_FDIV: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                        s0_reg <= l_rdata;
                        x0_reg <= signed'(p_rdata[47:24]);
                        y0_reg <= signed'(p_rdata[23:0]);
                    end else if (state_next == ST_MUL) begin
                        frac_reg <= (s1_reg > s0_reg && t_reg > s0_reg) ? drsp.quo[16:0] : 17'd0;
                    end
                end
                ST_MUL: begin
                    px_reg <= 43'(signed'({1'b0, frac_reg})) * 43'(25'(x1_reg) - 25'(x0_reg));
                    py_reg <= 43'(signed'({1'b0, frac_reg})) * 43'(25'(y1_reg) - 25'(y0_reg));
                end
                ST_ROUT: begin
                    if (!o_valid_reg) begin
                        o_valid_reg <= 1'b1;
                        o_rx_reg <= 24'(43'(x0_reg) + offx);
                        o_ry_reg <= 24'(43'(y0_reg) + offy);
                        o_eor_reg <= (i_reg + 7'd1) == tcs_reg;
                        i_reg <= i_reg + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // the walk re-reads entry u-1 in the cycle after ST_WCHK picks it
    assign m_valid          = o_valid_reg;
    assign m_rx             = o_rx_reg;
    assign m_ry             = o_ry_reg;
    assign m_end_of_run     = o_eor_reg;
    assign m_dropped_points = o_drop_reg;

    // hold: no input word taken while a run is being emitted
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    // drop: a word on the output holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rx) && $stable(m_ry)))
        else $error("output word changed while stalled");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count out of range");
endmodule
